/* rtl/first_fit_heap_allocator_top_defines.svh */
// Assertion macros used by the allocator top level.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define FFHA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ffha_pkg.sv */
package ffha_pkg;

   // default geometry
   localparam int HEAP_UNITS_DEF = 32768;
   localparam int UNIT_BYTES_DEF = 8;

   // fixed field widths
   localparam int BYTES_W = 19;
   localparam int UNIT_W  = 15;
   localparam int FREE_W  = 18;
   // rounded-up byte count, and the common compare width
   localparam int NUM_W   = BYTES_W + 1;
   localparam int CMP_W   = 22;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_STATUS  = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type             command;
      logic [BYTES_W-1:0]  request_bytes;
      logic [UNIT_W-1:0]   release_unit;
   } req_type;

   typedef struct packed {
      logic [UNIT_W-1:0]   granted_unit;
      logic                granted;
      logic [FREE_W-1:0]   free_bytes;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIV,
      ST_SETUP0,
      ST_SETUP1,
      ST_A_RD0,
      ST_A_P,
      ST_A_CHK,
      ST_A_SPLIT,
      ST_R_RD0,
      ST_R_WALK,
      ST_L1,
      ST_L2,
      ST_L3,
      ST_L4,
      ST_L5,
      ST_L6,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      state_type step;
      logic      load;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic rel_ok;
      logic heap_ready;
      logic fit;
      logic exact;
      logic tail_ok;
      logic p_zero;
      logic guard_end;
      logic walk_brk;
   } sts_type;

   // saturate at lim
   function automatic logic [CMP_W-1:0] sat(input logic [CMP_W-1:0] v,
                                            input logic [CMP_W-1:0] lim);
      return (v > lim) ? lim : v;
   endfunction

endpackage

/* rtl/ffha_ram.sv */
module ffha_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read (old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/ffha_ctrl.sv */
module ffha_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ffha_pkg::cmd_type command,
   input  ffha_pkg::sts_type sts,
   output ffha_pkg::ctl_type ctl,
   output logic              busy
);
   import ffha_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctl.step = state_ff;
      ctl.load = 1'b0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               unique case (command)
                  CMD_ALLOC:   state_in = ST_DIV;
                  CMD_RELEASE: state_in = sts.rel_ok ? ST_R_RD0 : ST_DONE;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_DIV:    state_in = sts.heap_ready ? ST_A_RD0 : ST_SETUP0;
         ST_SETUP0: state_in = ST_SETUP1;
         ST_SETUP1: state_in = ST_A_RD0;
         ST_A_RD0:  state_in = ST_A_P;
         ST_A_P:    state_in = ST_A_CHK;
         ST_A_CHK: begin
            if (sts.fit) begin
               state_in = (!sts.exact && sts.tail_ok) ? ST_A_SPLIT : ST_DONE;
            end else if (sts.p_zero || sts.guard_end) begin
               state_in = ST_DONE;
            end
         end
         ST_A_SPLIT: state_in = ST_DONE;
         ST_R_RD0:   state_in = ST_R_WALK;
         ST_R_WALK: begin
            if (sts.walk_brk) begin
               state_in = ST_L1;
            end else if (sts.guard_end) begin
               state_in = ST_DONE;
            end
         end
         ST_L1:   state_in = ST_L2;
         ST_L2:   state_in = ST_L3;
         ST_L3:   state_in = ST_L4;
         ST_L4:   state_in = ST_L5;
         ST_L5:   state_in = ST_L6;
         ST_L6:   state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

/* rtl/ffha_dp.sv */
module ffha_dp #(
   parameter int HEAP_UNITS = ffha_pkg::HEAP_UNITS_DEF,
   parameter int UNIT_BYTES = ffha_pkg::UNIT_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ffha_pkg::ctl_type ctl,
   input  ffha_pkg::req_type req_item,
   output ffha_pkg::sts_type sts,
   output logic              rsp_strobe,
   output ffha_pkg::rsp_type rsp_item
);
   import ffha_pkg::*;

   localparam int AW    = $clog2(HEAP_UNITS);
   localparam int GW    = $clog2(HEAP_UNITS + 1);
   localparam int RW    = $clog2(UNIT_BYTES);
   localparam logic [CMP_W-1:0] UNITS_C = CMP_W'(HEAP_UNITS);
   localparam logic [CMP_W-1:0] MAXSZ_C = CMP_W'(HEAP_UNITS - 1);
   // bytes to units: exact reciprocal multiply over the rounded-up byte count
   localparam int     SH     = NUM_W + RW;
   localparam int     RCP_W  = NUM_W + 1;
   localparam int     PROD_W = NUM_W + RCP_W;
   localparam longint RECIP  =
      ((longint'(1) << SH) + longint'(UNIT_BYTES) - 1) / longint'(UNIT_BYTES);
   localparam logic [RCP_W-1:0] RECIP_C = RCP_W'(RECIP);

   // RAM ports
   logic          link_we, size_we;
   logic [AW-1:0] link_wa, size_wa, link_wd, size_wd;
   logic [AW-1:0] link_ra, size_ra, link_rd, size_rd;

   ffha_ram #(.WIDTH(AW), .DEPTH(HEAP_UNITS)) u_link_ram (
      .clock(clock), .wr_en(link_we), .wr_addr(link_wa), .wr_data(link_wd),
      .rd_addr(link_ra), .rd_data(link_rd)
   );

   ffha_ram #(.WIDTH(AW), .DEPTH(HEAP_UNITS)) u_size_ram (
      .clock(clock), .wr_en(size_we), .wr_addr(size_wa), .wr_data(size_wd),
      .rd_addr(size_ra), .rd_data(size_rd)
   );

   // registers
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [AW-1:0]     hdr_ff, hdr_in, prev_ff, prev_in, p_ff, p_in, next_ff, next_in;
   logic [AW-1:0]     tail_ff, tail_in, szh_ff, szh_in, szn_ff, szn_in, total_ff, total_in;
   logic [GW-1:0]     guard_ff, guard_in;
   logic              first_ff, first_in, ready_ff, ready_in, granted_ff, granted_in;
   logic [UNIT_W-1:0] gunit_ff, gunit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
         total_ff <= '0;
      end else begin
         ready_ff <= ready_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      hdr_ff     <= hdr_in;
      prev_ff    <= prev_in;
      p_ff       <= p_in;
      next_ff    <= next_in;
      tail_ff    <= tail_in;
      szh_ff     <= szh_in;
      szn_ff     <= szn_in;
      guard_ff   <= guard_in;
      first_ff   <= first_in;
      granted_ff <= granted_in;
      gunit_ff   <= gunit_in;
   end

   // arithmetic on the node under test
   logic [CMP_W-1:0]  need_c, sz_c, rest_c, tail_c, tot_c, tot_dec_c, gnt_c, split_c;
   logic [CMP_W-1:0]  rel_c, hn_c, hp_c, fb_c;
   logic [PROD_W-1:0] prod_c;
   logic              m4, m5;

   always_comb begin
      need_c    = CMP_W'(quo_ff) + CMP_W'(1);
      sz_c      = CMP_W'(size_rd);
      rest_c    = sz_c - need_c;
      tail_c    = CMP_W'(p_ff) + rest_c;
      tot_c     = CMP_W'(total_ff);
      tot_dec_c = (tot_c > need_c) ? (tot_c - need_c) : '0;
      gnt_c     = CMP_W'(p_ff) + CMP_W'(1);
      split_c   = tail_c + CMP_W'(1);
      rel_c     = CMP_W'(req_item.release_unit);
      hn_c      = sat(CMP_W'(szh_ff) + CMP_W'(szn_ff), MAXSZ_C);
      hp_c      = sat(sz_c + CMP_W'(szh_ff), MAXSZ_C);
      m4        = (CMP_W'(hdr_ff) + CMP_W'(szh_ff)) == CMP_W'(next_ff);
      m5        = (prev_ff != '0) && ((sz_c + CMP_W'(prev_ff)) == CMP_W'(hdr_ff));
      fb_c      = tot_c * CMP_W'(UNIT_BYTES);
      prod_c    = PROD_W'(quo_ff) * PROD_W'(RECIP_C);
   end

   // status
   always_comb begin
      sts.rel_ok     = ready_ff && (rel_c > CMP_W'(1)) && (rel_c < UNITS_C);
      sts.heap_ready = ready_ff;
      sts.fit        = sz_c >= need_c;
      sts.exact      = sz_c == need_c;
      sts.tail_ok    = tail_c < UNITS_C;
      sts.p_zero     = p_ff == '0;
      sts.guard_end  = guard_ff == GW'(HEAP_UNITS);
      sts.walk_brk   = (!first_ff && (link_rd == '0)) || (link_rd > hdr_ff);
   end

   // per-step datapath actions
   always_comb begin
      quo_in     = quo_ff;
      hdr_in     = hdr_ff;
      prev_in    = prev_ff;
      p_in       = p_ff;
      next_in    = next_ff;
      tail_in    = tail_ff;
      szh_in     = szh_ff;
      szn_in     = szn_ff;
      guard_in   = guard_ff;
      first_in   = first_ff;
      ready_in   = ready_ff;
      total_in   = total_ff;
      granted_in = granted_ff;
      gunit_in   = gunit_ff;
      link_we    = 1'b0;
      size_we    = 1'b0;
      link_wa    = '0;
      size_wa    = '0;
      link_wd    = '0;
      size_wd    = '0;
      link_ra    = '0;
      size_ra    = '0;
      unique case (ctl.step)
         ST_IDLE: begin
            if (ctl.load) begin
               quo_in     = NUM_W'(req_item.request_bytes) + NUM_W'(UNIT_BYTES - 1);
               hdr_in     = AW'(rel_c - CMP_W'(1));
               prev_in    = '0;
               guard_in   = '0;
               first_in   = 1'b1;
               granted_in = 1'b0;
               gunit_in   = '0;
            end
         end
         // rounded-up bytes to units in one multiply
         ST_DIV: begin
            quo_in = NUM_W'(prod_c[PROD_W-1:SH]);
         end
         // sentinel links to one free block over the rest of the heap
         ST_SETUP0: begin
            link_we = 1'b1;
            link_wa = '0;
            link_wd = AW'(1);
            size_we = 1'b1;
            size_wa = '0;
            size_wd = '0;
         end
         ST_SETUP1: begin
            link_we  = 1'b1;
            link_wa  = AW'(1);
            link_wd  = '0;
            size_we  = 1'b1;
            size_wa  = AW'(1);
            size_wd  = AW'(HEAP_UNITS - 1);
            total_in = AW'(HEAP_UNITS - 1);
            ready_in = 1'b1;
         end
         ST_A_RD0: begin
            link_ra = '0;
         end
         ST_A_P: begin
            p_in    = link_rd;
            link_ra = link_rd;
            size_ra = link_rd;
         end
         // first-fit test, one node a cycle
         ST_A_CHK: begin
            if (sts.fit) begin
               if (sts.exact) begin
                  link_we    = 1'b1;
                  link_wa    = prev_ff;
                  link_wd    = link_rd;
                  total_in   = AW'(tot_dec_c);
                  granted_in = 1'b1;
                  gunit_in   = gnt_c[UNIT_W-1:0];
               end else if (sts.tail_ok) begin
                  size_we    = 1'b1;
                  size_wa    = p_ff;
                  size_wd    = AW'(rest_c);
                  tail_in    = AW'(tail_c);
                  total_in   = AW'(tot_dec_c);
                  granted_in = 1'b1;
                  gunit_in   = split_c[UNIT_W-1:0];
               end
            end else begin
               prev_in  = p_ff;
               p_in     = link_rd;
               guard_in = guard_ff + GW'(1);
               link_ra  = link_rd;
               size_ra  = link_rd;
            end
         end
         ST_A_SPLIT: begin
            size_we = 1'b1;
            size_wa = tail_ff;
            size_wd = AW'(need_c);
         end
         ST_R_RD0: begin
            link_ra = '0;
         end
         // address-ordered search for the insert point
         ST_R_WALK: begin
            if (sts.walk_brk) begin
               next_in = link_rd;
            end else begin
               prev_in  = link_rd;
               first_in = 1'b0;
               guard_in = guard_ff + GW'(1);
               link_ra  = link_rd;
            end
         end
         ST_L1: begin
            link_we = 1'b1;
            link_wa = hdr_ff;
            link_wd = next_ff;
            size_ra = hdr_ff;
         end
         ST_L2: begin
            link_we  = 1'b1;
            link_wa  = prev_ff;
            link_wd  = hdr_ff;
            szh_in   = size_rd;
            total_in = AW'(sat(tot_c + sz_c, MAXSZ_C));
            size_ra  = next_ff;
         end
         ST_L3: begin
            szn_in  = size_rd;
            link_ra = next_ff;
         end
         // merge with the following block
         ST_L4: begin
            if (m4) begin
               size_we = 1'b1;
               size_wa = hdr_ff;
               size_wd = AW'(hn_c);
               szh_in  = AW'(hn_c);
               link_we = 1'b1;
               link_wa = hdr_ff;
               link_wd = link_rd;
            end
         end
         ST_L5: begin
            size_ra = prev_ff;
            link_ra = hdr_ff;
         end
         // merge into the preceding block
         ST_L6: begin
            if (m5) begin
               size_we = 1'b1;
               size_wa = prev_ff;
               size_wd = AW'(hp_c);
               link_we = 1'b1;
               link_wa = prev_ff;
               link_wd = link_rd;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // result beat
   assign rsp_strobe            = (ctl.step == ST_DONE);
   assign rsp_item.granted_unit = gunit_ff;
   assign rsp_item.granted      = granted_ff;
   assign rsp_item.free_bytes   = ready_ff ? fb_c[FREE_W-1:0] : '0;
endmodule

/* rtl/first_fit_heap_allocator_top.sv */
// First-fit heap allocator. A request is taken when start is high and busy
// is low; exactly one result beat follows, shown for a single cycle with
// rsp_strobe high, and it cannot be held off. A status command or an ignored
// release goes straight to the result. An allocate takes the beat, turns bytes
// into units (one reciprocal multiply), builds the heap on the very first
// allocate, reads the sentinel to reach the first free block, tests one
// free-list node per cycle, splits the block if needed and gives the result.
// A release reads the sentinel, walks one free-list node per cycle below the
// released block (an empty list counts the sentinel) to find the insert
// point, links the block in, merges it with the following and the preceding
// block and gives the result. On a corrupted list a walk stops after
// HEAP_UNITS+1 nodes. The walk rate is set by the registered read ports of
// the link and size memories; busy stays high for the whole request.
`include "first_fit_heap_allocator_top_defines.svh"

module first_fit_heap_allocator_top #(
   parameter int HEAP_UNITS = ffha_pkg::HEAP_UNITS_DEF,
   parameter int UNIT_BYTES = ffha_pkg::UNIT_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffha_pkg::req_type req_item,
   output logic              rsp_strobe,
   output ffha_pkg::rsp_type rsp_item
);
   import ffha_pkg::*;

   ctl_type ctl;
   sts_type sts;

   ffha_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .command(req_item.command),
      .sts(sts), .ctl(ctl), .busy(busy)
   );

   ffha_dp #(.HEAP_UNITS(HEAP_UNITS), .UNIT_BYTES(UNIT_BYTES)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .req_item(req_item), .sts(sts),
      .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   // checks
   `FFHA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
   `FFHA_ASSERT_NEXT(a_beat_frees, rsp_strobe, !busy && !rsp_strobe, "result beat not single")
   `FFHA_ASSERT_NOW(a_fail_zero, rsp_strobe && !rsp_item.granted, rsp_item.granted_unit == '0, "failed grant has unit")
endmodule
